[hdl/bcrw_pkg.sv]
package bcrw_pkg;

  // field widths fixed by the device register map
  localparam int BRIGHT_W = 9;
  localparam int IDX_W    = 5;
  localparam int CODE_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int ENT_W    = 6;

  // default geometry of the curve
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_STEP_SIZE   = 10;

  // device register addresses
  localparam logic [BYTE_W-1:0] REG_B_LSB   = 8'h22;
  localparam logic [BYTE_W-1:0] REG_B_MSB   = 8'h23;
  localparam logic [BYTE_W-1:0] REG_BOOST   = 8'h1A;
  localparam logic [BYTE_W-1:0] REG_PWM     = 8'h1C;
  localparam logic [BYTE_W-1:0] REG_BANK_EN = 8'h24;

  // bit of the bank enable byte that turns on bank B brightness writes
  localparam int BANK_B_BIT = 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOST,
    CFG_PWM,
    CFG_BANK_EN,
    CFG_ENTRIES
  } cfg_idx_t;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] boost_setting;
    logic [BYTE_W-1:0] pwm_setting;
    logic [BYTE_W-1:0] bank_enable_mask;
    logic [ENT_W-1:0]  table_entries;
  } cfg_t;

  // one finished set request handed to the write sequencer
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              bright_nz;
  } emit_item_t;

endpackage

[hdl/bcrw_ifs.sv]
interface bcrw_in_if import bcrw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [BRIGHT_W-1:0] brightness;
  logic [IDX_W-1:0]    entry_index;
  logic [CODE_W-1:0]   entry_value;

  modport source (output valid, op, brightness, entry_index, entry_value, input ready);
  modport sink (input valid, op, brightness, entry_index, entry_value, output ready);
endinterface

interface bcrw_out_if import bcrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] reg_address;
  logic [BYTE_W-1:0] reg_data;
  logic [CODE_W-1:0] interp_code;
  logic              last;

  modport source (output valid, reg_address, reg_data, interp_code, last, input ready);
  modport sink (input valid, reg_address, reg_data, interp_code, last, output ready);
endinterface

[hdl/bcrw_emit.sv]
module bcrw_emit import bcrw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  emit_item_t item,
  output logic       item_free,
  bcrw_out_if.source wr
);

  typedef enum logic [2:0] {
    SLOT_B_LSB,
    SLOT_B_MSB,
    SLOT_BOOST,
    SLOT_PWM,
    SLOT_BANK_EN
  } slot_t;

  logic              busy;
  logic              enabled;
  slot_t             slot;
  slot_t             slot_end;
  logic [CODE_W-1:0] code;
  logic              bank_b;
  logic              is_last;
  logic              take;

  assign bank_b    = cfg.bank_enable_mask[BANK_B_BIT];
  assign is_last   = (slot == slot_end);
  assign item_free = !busy || (wr.ready && is_last);
  assign take      = item_valid && item_free;

  // write sequence: bank B pair if bank B is on, then the re-enable triple if the device was off
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      enabled  <= 1'b1;
      slot     <= SLOT_B_LSB;
      slot_end <= SLOT_B_LSB;
    end else begin
      priority if (take) begin
        busy     <= bank_b || !enabled;
        slot     <= bank_b ? SLOT_B_LSB : SLOT_BOOST;
        slot_end <= enabled ? SLOT_B_MSB : SLOT_BANK_EN;
        enabled  <= item.bright_nz;
        code     <= item.code;
      end else if (busy && wr.ready) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          slot <= slot_t'(slot + 3'd1);
        end
      end
    end
  end

  // address and data of the current write
  always_comb begin
    case (slot)
      SLOT_B_LSB: begin
        wr.reg_address = REG_B_LSB;
        wr.reg_data    = {5'd0, code[2:0]};
      end
      SLOT_B_MSB: begin
        wr.reg_address = REG_B_MSB;
        wr.reg_data    = code[10:3];
      end
      SLOT_BOOST: begin
        wr.reg_address = REG_BOOST;
        wr.reg_data    = cfg.boost_setting;
      end
      SLOT_PWM: begin
        wr.reg_address = REG_PWM;
        wr.reg_data    = cfg.pwm_setting;
      end
      SLOT_BANK_EN: begin
        wr.reg_address = REG_BANK_EN;
        wr.reg_data    = cfg.bank_enable_mask;
      end
      default: begin
        wr.reg_address = '0;
        wr.reg_data    = '0;
      end
    endcase
  end

  assign wr.valid       = busy;
  assign wr.interp_code = code;
  assign wr.last        = is_last;

endmodule

[hdl/brightness_curve_register_writer.sv]
// Backlight curve interpolator and register write generator.
// req: a load (op 0) stores entry_value at entry_index in the curve memory
// and produces nothing; a set (op 1) interpolates the curve at brightness and
// produces zero to five register writes on wr, the final one marked by last.
// cfg_we/cfg_index/cfg_data write the four settings; change them only while
// no request is in flight.
// A set passes a ten stage pipeline, then the write sequencer offers its
// writes on wr. Throughput: one request per cycle while the sequencer keeps
// up; a set holds the sequencer until each of its writes has been taken on
// wr (five when re-enabling with bank B on), and the sequencer takes the next
// set with the last write of the one before. The sequencer with its single
// output port sets that limit.
// A stalled receiver freezes the whole pipeline, bubbles included, once its
// last stage holds a set the sequencer cannot take; req.ready drops with it.
// Reset empties the pipeline, marks the device enabled and loads the setting
// defaults (two table entries); the curve memory keeps its contents and must
// be loaded before use.
module brightness_curve_register_writer import bcrw_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int STEP_SIZE   = DEF_STEP_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bcrw_in_if.sink               req,
  bcrw_out_if.source            wr
);

  localparam int IW  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW  = $clog2(STEP_SIZE);
  localparam int EW  = $clog2(TABLE_DEPTH + 1);
  localparam int MXW = $clog2(STEP_SIZE * TABLE_DEPTH + 1);
  localparam int BW  = BRIGHT_W;
  // reciprocal for the brightness split
  localparam int K1    = BW + 1;
  localparam int PW1   = BW + K1;
  localparam int RECIP1 = (1 << K1) / STEP_SIZE;
  // reciprocal for the slope scaling
  localparam int MW    = CODE_W + RW;
  localparam int K2    = MW + 1;
  localparam int PW2   = MW + K2;
  localparam int RECIP2 = (1 << K2) / STEP_SIZE;

  cfg_t cfg;

  // settings derived from the entry count
  logic [EW-1:0]  ent_c;
  logic [IW-1:0]  ent_m1;
  logic [MXW-1:0] maxb;

  logic adv;
  logic emit_free;

  // pipeline registers
  logic              v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic              op1, op2, op3, op4, op5;
  logic [BW-1:0]     br1, br2, br3, br4;
  logic [IDX_W-1:0]  idx1, idx2, idx3, idx4, idx5;
  logic [CODE_W-1:0] val1, val2, val3, val4, val5;
  logic [BW-1:0]     q3, q4;
  logic [BW-1:0]     p4;
  logic [IW-1:0]     lo5, hi5;
  logic [RW-1:0]     rem5, rem6;
  logic              nz5, nz6, nz7, nz8, nz9, nz10;
  logic [CODE_W-1:0] c1_6, c2_6, c1_7, c1_8, c1_9;
  logic              neg7, neg8, neg9;
  logic [MW-1:0]     mag7, mag8, mag9;
  logic [MW-1:0]     q8, q9, p9;
  logic [CODE_W-1:0] code10;

  logic [CODE_W-1:0] curve_mem [TABLE_DEPTH];

  // combinational stage results
  logic [BW-1:0]     br_sat;
  logic [BW-1:0]     q_est1;
  logic [BW-1:0]     rem_raw;
  logic              fix1;
  logic [BW-1:0]     lo_full;
  logic [IW-1:0]     lo_c, hi_c;
  logic [RW-1:0]     rem_c;
  logic              idx_ok;
  logic              neg_d;
  logic [CODE_W-1:0] absd;
  logic [MW-1:0]     q_est2;
  logic [MW-1:0]     r_raw;
  logic [MW-1:0]     q_fin;
  logic [CODE_W-1:0] code_d;

  emit_item_t item;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boost_setting    <= '0;
      cfg.pwm_setting      <= '0;
      cfg.bank_enable_mask <= '0;
      cfg.table_entries    <= ENT_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOOST:   cfg.boost_setting    <= cfg_data;
        CFG_PWM:     cfg.pwm_setting      <= cfg_data;
        CFG_BANK_EN: cfg.bank_enable_mask <= cfg_data;
        CFG_ENTRIES: cfg.table_entries    <= cfg_data[ENT_W-1:0];
      endcase
    end
  end

  // entry count clamped to 2..TABLE_DEPTH
  always_comb begin
    if (32'(cfg.table_entries) < 2) begin
      ent_c = EW'(2);
    end else if (32'(cfg.table_entries) > TABLE_DEPTH) begin
      ent_c = EW'(TABLE_DEPTH);
    end else begin
      ent_c = EW'(cfg.table_entries);
    end
  end

  always_ff @(posedge clk) begin
    ent_m1 <= IW'(ent_c - EW'(1));
    maxb   <= MXW'((32'(ent_c) - 32'd1) * STEP_SIZE);
  end

  // stage arithmetic
  always_comb begin
    br_sat = (32'(br1) > 32'(maxb)) ? BW'(maxb) : br1;
    q_est1 = BW'((PW1'(br2) * PW1'(RECIP1)) >> K1);

    rem_raw = br4 - p4;
    fix1    = (32'(rem_raw) >= STEP_SIZE);
    lo_full = q4 + BW'(fix1);
    rem_c   = fix1 ? RW'(32'(rem_raw) - STEP_SIZE) : RW'(rem_raw);
    lo_c    = (32'(lo_full) > 32'(ent_m1)) ? ent_m1 : IW'(lo_full);
    hi_c    = (lo_c == ent_m1) ? ent_m1 : IW'(lo_c + IW'(1));

    idx_ok  = (32'(idx5) < TABLE_DEPTH);

    neg_d   = (c2_6 < c1_6);
    absd    = neg_d ? (c1_6 - c2_6) : (c2_6 - c1_6);
    q_est2  = MW'((PW2'(mag7) * PW2'(RECIP2)) >> K2);

    r_raw   = mag9 - p9;
    q_fin   = q9 + MW'(32'(r_raw) >= STEP_SIZE);
    code_d  = neg9 ? (c1_9 - CODE_W'(q_fin)) : (c1_9 + CODE_W'(q_fin));
  end

  assign adv       = !v10 || emit_free;
  assign req.ready = adv;

  // pipeline occupancy; loads leave after the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10} <= '0;
    end else if (adv) begin
      v1  <= req.valid;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5 && (op5 == OP_SET);
      v7  <= v6;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      op1  <= req.op;
      br1  <= req.brightness;
      idx1 <= req.entry_index;
      val1 <= req.entry_value;

      op2  <= op1;
      br2  <= br_sat;
      idx2 <= idx1;
      val2 <= val1;

      op3  <= op2;
      br3  <= br2;
      idx3 <= idx2;
      val3 <= val2;
      q3   <= q_est1;

      op4  <= op3;
      br4  <= br3;
      idx4 <= idx3;
      val4 <= val3;
      q4   <= q3;
      p4   <= BW'(32'(q3) * STEP_SIZE);

      op5  <= op4;
      idx5 <= idx4;
      val5 <= val4;
      lo5  <= lo_c;
      hi5  <= hi_c;
      rem5 <= rem_c;
      nz5  <= (br4 != '0);

      rem6 <= rem5;
      nz6  <= nz5;

      neg7 <= neg_d;
      c1_7 <= c1_6;
      mag7 <= MW'(MW'(absd) * MW'(rem6));
      nz7  <= nz6;

      neg8 <= neg7;
      c1_8 <= c1_7;
      mag8 <= mag7;
      q8   <= q_est2;
      nz8  <= nz7;

      neg9 <= neg8;
      c1_9 <= c1_8;
      mag9 <= mag8;
      q9   <= q8;
      p9   <= MW'(PW2'(q8) * PW2'(STEP_SIZE));
      nz9  <= nz8;

      code10 <= code_d;
      nz10   <= nz9;
    end
  end

  // curve memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v5 && (op5 == OP_LOAD) && idx_ok) begin
        curve_mem[IW'(idx5)] <= val5;
      end
      c1_6 <= curve_mem[lo5];
      c2_6 <= curve_mem[hi5];
    end
  end

  assign item.code      = code10;
  assign item.bright_nz = nz10;

  bcrw_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (v10),
    .item       (item),
    .item_free  (emit_free),
    .wr         (wr)
  );

  // brightness split needs at most one correction step
  a_split_rem: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (32'(rem_raw) < 2 * STEP_SIZE))
    else $error("brightness quotient estimate off by more than one");

  // slope scaling needs at most one correction step
  a_scale_rem: assert property (@(posedge clk) disable iff (rst)
    v9 |-> (32'(r_raw) < 2 * STEP_SIZE))
    else $error("slope quotient estimate off by more than one");

  // a finished code waits in the last stage while the sequencer is busy
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    (v10 && !emit_free) |=> (v10 && $stable(code10)))
    else $error("pending result lost while sequencer busy");

endmodule
